[sv/lfr_pkg.sv]
// ----------------------------------------------------------------------------
// lfr_pkg
// shared types and constants for the lru frame replacer
// ----------------------------------------------------------------------------
package lfr_pkg;
   localparam int NumFrames = 64;
   localparam int FrameW    = $clog2(NumFrames);
   localparam int CountW    = $clog2(NumFrames + 1);

   typedef enum logic [1:0] {
      OP_VICTIM = 2'd0,
      OP_PIN    = 2'd1,
      OP_UNPIN  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_APPEND,
      ST_DONE
   } state_type;

   localparam logic [0:0] ADDR_CAPACITY = 1'b0;
endpackage

[sv/lfr_ram.sv]
// ----------------------------------------------------------------------------
// lfr_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module lfr_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[sv/lru_frame_replacer.sv]
// ----------------------------------------------------------------------------
// lru_frame_replacer
// lru replacer with pinning, recency order held in a ram
// ----------------------------------------------------------------------------
// a pin needs no ram pass; a victim scans the order and closes the gap, an unpin may also append
// the order ram has one read and one write port: scan reads one entry a
// cycle, the gap close shifts one entry a cycle
// throughput: one transaction at a time, next accepted the cycle after the result is taken
// reset: flags, counts and capacity (64) reset at once, no clearing pass
module lru_frame_replacer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [5:0]  req_frame,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [5:0]  rsp_victim_frame,
   output logic [6:0]  rsp_evictable_count,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int FW = lfr_pkg::FrameW;
   localparam int CW = lfr_pkg::CountW;

   lfr_pkg::state_type state_ff, state_in;
   logic [lfr_pkg::NumFrames-1:0] tracked_ff, tracked_in, evict_ff, evict_in;
   logic [CW-1:0] len_ff, len_in, total_ff, total_in, cap_ff;
   logic [CW-1:0] pos_ff, pos_in;
   logic          rd_pend_ff, rd_pend_in;
   lfr_pkg::op_type op_ff, op_in;
   logic [FW-1:0] frame_ff, frame_in;
   logic          found_ff, found_in, rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0] victim_ff, victim_in;

   logic          wr_en;
   logic [FW-1:0] wr_addr, wr_data, rd_addr, rd_data;

   lfr_ram #(.Width(FW), .Depth(lfr_pkg::NumFrames)) u_order (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // csr
   logic cfg_wr;
   assign cfg_wr = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == lfr_pkg::ADDR_CAPACITY) ? {25'd0, cap_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CW'(64);
      end else if (cfg_wr && paddr[2] == lfr_pkg::ADDR_CAPACITY) begin
         cap_ff <= pwdata[CW-1:0];
      end
   end

   assign req_ready = (state_ff == lfr_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = found_ff;
   assign rsp_victim_frame = victim_ff;
   assign rsp_evictable_count = total_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lfr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = lfr_pkg::ST_DONE;
               if (lfr_pkg::op_type'(req_op) == lfr_pkg::OP_VICTIM) begin
                  state_in = lfr_pkg::ST_SCAN;
               end else if (lfr_pkg::op_type'(req_op) == lfr_pkg::OP_UNPIN) begin
                  if (tracked_ff[req_frame]) begin
                     if (!evict_ff[req_frame]) state_in = lfr_pkg::ST_SCAN;
                  end else if (total_ff < cap_ff && len_ff < CW'(lfr_pkg::NumFrames)) begin
                     state_in = lfr_pkg::ST_APPEND;
                  end
               end
            end
         end
         lfr_pkg::ST_SCAN: begin
            if (rd_pend_ff) begin
               if ((op_ff == lfr_pkg::OP_VICTIM && evict_ff[rd_data]) ||
                   (op_ff == lfr_pkg::OP_UNPIN && rd_data == frame_ff)) begin
                  state_in = lfr_pkg::ST_SHIFT;
               end else if (pos_ff + CW'(1) >= len_ff) begin
                  state_in = lfr_pkg::ST_DONE;
               end
            end else if (pos_ff >= len_ff) begin
               state_in = lfr_pkg::ST_DONE;
            end
         end
         lfr_pkg::ST_SHIFT: begin
            if (pos_ff + CW'(1) >= len_ff) begin
               state_in = (op_ff == lfr_pkg::OP_UNPIN) ? lfr_pkg::ST_APPEND : lfr_pkg::ST_DONE;
            end
         end
         lfr_pkg::ST_APPEND: state_in = lfr_pkg::ST_DONE;
         lfr_pkg::ST_DONE: if (rsp_ready && rsp_valid_ff) state_in = lfr_pkg::ST_IDLE;
         default: state_in = lfr_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      tracked_in = tracked_ff;
      evict_in = evict_ff;
      len_in = len_ff;
      total_in = total_ff;
      pos_in = pos_ff;
      rd_pend_in = 1'b0;
      op_in = op_ff;
      frame_in = frame_ff;
      found_in = found_ff;
      victim_in = victim_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en = 1'b0;
      wr_addr = pos_ff[FW-1:0];
      wr_data = rd_data;
      rd_addr = pos_ff[FW-1:0];
      unique case (state_ff)
         lfr_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in = lfr_pkg::op_type'(req_op);
               frame_in = req_frame;
               found_in = 1'b0;
               victim_in = '0;
               pos_in = '0;
               rd_addr = '0;
               rd_pend_in = (len_ff != '0);
               if (lfr_pkg::op_type'(req_op) == lfr_pkg::OP_PIN &&
                   tracked_ff[req_frame] && evict_ff[req_frame]) begin
                  evict_in[req_frame] = 1'b0;
                  if (total_ff != '0) total_in = total_ff - CW'(1);
               end
               if (lfr_pkg::op_type'(req_op) == lfr_pkg::OP_UNPIN &&
                   tracked_ff[req_frame] && !evict_ff[req_frame]) begin
                  evict_in[req_frame] = 1'b1;
                  total_in = total_ff + CW'(1);
               end
               if (lfr_pkg::op_type'(req_op) == lfr_pkg::OP_UNPIN &&
                   !tracked_ff[req_frame] && total_ff < cap_ff &&
                   len_ff < CW'(lfr_pkg::NumFrames)) begin
                  tracked_in[req_frame] = 1'b1;
                  evict_in[req_frame] = 1'b1;
                  total_in = total_ff + CW'(1);
               end
            end
         end
         lfr_pkg::ST_SCAN: begin
            if (rd_pend_ff) begin
               if (op_ff == lfr_pkg::OP_VICTIM && evict_ff[rd_data]) begin
                  found_in = 1'b1;
                  victim_in = rd_data;
                  tracked_in[rd_data] = 1'b0;
                  evict_in[rd_data] = 1'b0;
                  if (total_ff != '0) total_in = total_ff - CW'(1);
                  rd_addr = FW'(pos_ff + CW'(1));
                  rd_pend_in = 1'b1;
               end else if (op_ff == lfr_pkg::OP_UNPIN && rd_data == frame_ff) begin
                  rd_addr = FW'(pos_ff + CW'(1));
                  rd_pend_in = 1'b1;
               end else begin
                  pos_in = pos_ff + CW'(1);
                  rd_addr = FW'(pos_ff + CW'(1));
                  rd_pend_in = (pos_ff + CW'(1) < len_ff);
               end
            end
         end
         lfr_pkg::ST_SHIFT: begin
            // rd_data holds entry pos+1 when one exists
            if (pos_ff + CW'(1) < len_ff) begin
               wr_en = 1'b1;
               wr_addr = pos_ff[FW-1:0];
               wr_data = rd_data;
               pos_in = pos_ff + CW'(1);
               rd_addr = FW'(pos_ff + CW'(2));
            end else begin
               len_in = len_ff - CW'(1);
               pos_in = len_ff - CW'(1);
            end
         end
         lfr_pkg::ST_APPEND: begin
            wr_en = 1'b1;
            wr_addr = len_ff[FW-1:0];
            wr_data = frame_ff;
            len_in = len_ff + CW'(1);
         end
         lfr_pkg::ST_DONE: begin
            if (!rsp_valid_ff) rsp_valid_in = 1'b1;
            else if (rsp_ready) rsp_valid_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfr_pkg::ST_IDLE;
         tracked_ff <= '0;
         evict_ff <= '0;
         len_ff <= '0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tracked_ff <= tracked_in;
         evict_ff <= evict_in;
         len_ff <= len_in;
         total_ff <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      op_ff <= op_in;
      frame_ff <= frame_in;
      found_ff <= found_in;
      victim_ff <= victim_in;
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CW'(lfr_pkg::NumFrames)) else $error("order length overflow");
   a_total_le_len: assert property (@(posedge clock) disable iff (reset)
      total_ff <= len_ff || state_ff != lfr_pkg::ST_IDLE) else $error("count exceeds order");
   a_evict_tracked: assert property (@(posedge clock) disable iff (reset)
      (evict_ff & ~tracked_ff) == '0) else $error("evictable frame not tracked");
   a_rsp_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == lfr_pkg::ST_DONE) else $error("result outside done");
endmodule
